// ----- sv/tbb_pkg.sv -----
// Shared types, constants and helpers for the transformed box bounds core.
// Used by tbb_mac and transformed_box_bounds_core; no dependencies.
package tbb_pkg;

    localparam int MAX_CHAIN = 64;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int MAT_DEPTH = 16;
    localparam int ADDR_W    = 4;
    localparam int CNT_W     = $clog2(MAX_CHAIN + 1);

    localparam logic signed [DATA_W-1:0] ONE_FX     = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] NEG_ONE_FX = -ONE_FX;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_ROW_WAIT,
        ST_COPY,
        ST_COPY_WAIT,
        ST_CORNER,
        ST_CORNER_WAIT,
        ST_OUT
    } state_t;

    // Tag that travels with one multiply-accumulate term
    typedef struct packed {
        logic       valid;
        logic       corner;  // corner pass, else matrix row pass
        logic [1:0] k;       // term index within the dot product
        logic [1:0] j;       // product column or corner axis
        logic [2:0] n;       // corner number
    } op_tag_t;

    // Identity matrix entry, row-major address
    function automatic logic signed [DATA_W-1:0] identity_elem(input logic [ADDR_W-1:0] addr);
        logic signed [DATA_W-1:0] v;
        v = (addr[3:2] == addr[1:0]) ? ONE_FX : '0;
        return v;
    endfunction

endpackage

// ----- sv/tbb_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module tbb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/tbb_mac.sv -----
// Saturating fixed point multiply-accumulate: registered 32x32 product, then
// floor shift, saturate, add and saturate. Depends on tbb_pkg.
module tbb_mac (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tbb_pkg::op_tag_t                 in_tag,
    input  logic signed [tbb_pkg::DATA_W-1:0] in_a,
    input  logic signed [tbb_pkg::DATA_W-1:0] in_b,
    output tbb_pkg::op_tag_t                 out_tag,
    output logic signed [tbb_pkg::DATA_W-1:0] out_res,
    output logic                             out_sat
);

    localparam logic signed [63:0] MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] MIN64 = -64'sd2147483648;

    tbb_pkg::op_tag_t                  tag_reg;
    logic signed [63:0]                prod_reg;
    logic signed [tbb_pkg::DATA_W-1:0] acc_reg;
    logic signed [63:0]                a_ext, b_ext, shifted;
    logic signed [tbb_pkg::DATA_W-1:0] mul_val, acc_base;
    logic signed [tbb_pkg::DATA_W:0]   sum;
    logic                              mul_sat, add_sat;

    assign a_ext = $signed({{32{in_a[31]}}, in_a});
    assign b_ext = $signed({{32{in_b[31]}}, in_b});

    // product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg.valid <= 1'b0;
        end else begin
            tag_reg.valid <= in_tag.valid;
        end
        tag_reg.corner <= in_tag.corner;
        tag_reg.k      <= in_tag.k;
        tag_reg.j      <= in_tag.j;
        tag_reg.n      <= in_tag.n;
        prod_reg       <= a_ext * b_ext;
    end

    // rescale, saturate and accumulate
    always_comb begin
        shifted = prod_reg >>> tbb_pkg::FRAC_BITS;
        mul_sat = 1'b0;
        if (shifted > MAX64) begin
            mul_val = 32'sh7FFFFFFF;
            mul_sat = 1'b1;
        end else if (shifted < MIN64) begin
            mul_val = 32'sh80000000;
            mul_sat = 1'b1;
        end else begin
            mul_val = shifted[31:0];
        end
        acc_base = (tag_reg.k == 2'd0) ? '0 : acc_reg;
        sum      = $signed({acc_base[31], acc_base}) + $signed({mul_val[31], mul_val});
        add_sat  = (sum[32] != sum[31]);
        if (add_sat) begin
            out_res = sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            out_res = sum[31:0];
        end
        out_sat = tag_reg.valid && (mul_sat || add_sat);
    end

    always_ff @(posedge aclk) begin
        if (tag_reg.valid) begin
            acc_reg <= out_res;
        end
    end

    assign out_tag = tag_reg;

endmodule

// ----- sv/transformed_box_bounds_core.sv -----
// Bounding box of the cube [-1,1]^3 under a chain of 4x4 Q16.16 matrices sent
// one row per request, leaf first. Depends on tbb_pkg, tbb_ram and tbb_mac.
// Each row request sends its 16 terms through the single multiply-accumulate
// unit and then drains it; row 3 then also copies the product memory into
// the world memory one word a cycle. The request that ends the chain then
// sends the 96 corner terms through it, and the result is held until taken;
// no new request is taken meanwhile.
// Matrices past MAX_CHAIN are ignored and flagged; saturation is flagged.
module transformed_box_bounds_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_row_elem_0,
    input  logic signed [31:0] s_row_elem_1,
    input  logic signed [31:0] s_row_elem_2,
    input  logic signed [31:0] s_row_elem_3,
    input  logic [1:0]         s_row_index,
    input  logic               s_chain_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_min_x,
    output logic signed [31:0] m_min_y,
    output logic signed [31:0] m_min_z,
    output logic signed [31:0] m_max_x,
    output logic signed [31:0] m_max_y,
    output logic signed [31:0] m_max_z,
    output logic               m_chain_truncated,
    output logic               m_saturated
);

    localparam int DW = tbb_pkg::DATA_W;
    localparam int AW = tbb_pkg::ADDR_W;

    tbb_pkg::state_t  state_reg, state_next;
    logic signed [DW-1:0] row_reg [4];
    logic [1:0]       r_reg;
    logic             end_reg;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [2:0]       n_reg, n_next;
    logic [tbb_pkg::CNT_W-1:0] count_reg;
    logic             trunc_reg, sat_reg;
    logic [tbb_pkg::MAT_DEPTH-1:0] wvalid_reg;
    tbb_pkg::op_tag_t tag0, tag1_reg, mac_tag;
    logic [AW-1:0]    waddr1_reg, w_raddr;
    logic             copy1_reg;
    logic signed [DW-1:0] lo_reg [3];
    logic signed [DW-1:0] hi_reg [3];

    logic             accept, end_in, out_done, under_limit;
    logic             issue_row, issue_copy, issue_corner;
    logic             row_last, corner_last, drained;
    logic [DW-1:0]    w_rdata, p_rdata;
    logic signed [DW-1:0] world_eff, op_a, op_b, mac_res;
    logic             mac_sat, v_bit, p_we;

    assign accept      = s_valid && s_ready;
    assign out_done    = m_valid && m_ready;
    assign end_in      = s_chain_end && (s_row_index == 2'd3);
    assign under_limit = (count_reg < tbb_pkg::CNT_W'(tbb_pkg::MAX_CHAIN));
    assign row_last    = (cnt_reg == 4'd15);
    assign corner_last = (n_reg == 3'd7) && (cnt_reg == {2'd2, 2'd3});
    assign drained     = !tag1_reg.valid && !mac_tag.valid;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tbb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (under_limit) begin
                        state_next = tbb_pkg::ST_ROW;
                    end else if (end_in) begin
                        state_next = tbb_pkg::ST_CORNER;
                    end
                end
            end
            tbb_pkg::ST_ROW: begin
                if (row_last) state_next = tbb_pkg::ST_ROW_WAIT;
            end
            tbb_pkg::ST_ROW_WAIT: begin
                if (drained) begin
                    state_next = (r_reg == 2'd3) ? tbb_pkg::ST_COPY : tbb_pkg::ST_IDLE;
                end
            end
            tbb_pkg::ST_COPY: begin
                if (row_last) state_next = tbb_pkg::ST_COPY_WAIT;
            end
            tbb_pkg::ST_COPY_WAIT: begin
                if (!copy1_reg) begin
                    state_next = end_reg ? tbb_pkg::ST_CORNER : tbb_pkg::ST_IDLE;
                end
            end
            tbb_pkg::ST_CORNER: begin
                if (corner_last) state_next = tbb_pkg::ST_CORNER_WAIT;
            end
            tbb_pkg::ST_CORNER_WAIT: begin
                if (drained) state_next = tbb_pkg::ST_OUT;
            end
            tbb_pkg::ST_OUT: begin
                if (m_ready) state_next = tbb_pkg::ST_IDLE;
            end
            default: state_next = tbb_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        issue_row    = 1'b0;
        issue_copy   = 1'b0;
        issue_corner = 1'b0;
        case (state_reg)
            tbb_pkg::ST_IDLE:   s_ready      = 1'b1;
            tbb_pkg::ST_ROW:    issue_row    = 1'b1;
            tbb_pkg::ST_COPY:   issue_copy   = 1'b1;
            tbb_pkg::ST_CORNER: issue_corner = 1'b1;
            tbb_pkg::ST_OUT:    m_valid      = 1'b1;
            default: ;
        endcase
    end

    // term counters: k in cnt[1:0], column or axis in cnt[3:2]
    always_comb begin
        cnt_next = cnt_reg;
        n_next   = n_reg;
        if (issue_row || issue_copy) begin
            cnt_next = cnt_reg + 4'd1;
        end else if (issue_corner) begin
            if (cnt_reg == {2'd2, 2'd3}) begin
                cnt_next = '0;
                n_next   = n_reg + 3'd1;
            end else begin
                cnt_next = cnt_reg + 4'd1;
            end
        end
    end

    // issue: row pass reads world[k][c], otherwise address is the counter
    assign w_raddr    = issue_row ? {cnt_reg[1:0], cnt_reg[3:2]} : cnt_reg;
    assign tag0.valid  = issue_row || issue_corner;
    assign tag0.corner = issue_corner;
    assign tag0.k      = cnt_reg[1:0];
    assign tag0.j      = cnt_reg[3:2];
    assign tag0.n      = n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tbb_pkg::ST_IDLE;
            cnt_reg        <= '0;
            n_reg          <= '0;
            count_reg      <= '0;
            trunc_reg      <= 1'b0;
            sat_reg        <= 1'b0;
            wvalid_reg     <= '0;
            tag1_reg.valid <= 1'b0;
            copy1_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            n_reg          <= n_next;
            tag1_reg.valid <= tag0.valid;
            copy1_reg      <= issue_copy;
            if (accept && !under_limit) trunc_reg <= 1'b1;
            if (mac_sat) sat_reg <= 1'b1;
            if (copy1_reg) wvalid_reg[waddr1_reg] <= 1'b1;
            if (state_reg == tbb_pkg::ST_COPY_WAIT && !copy1_reg) begin
                count_reg <= count_reg + tbb_pkg::CNT_W'(1);
            end
            if (out_done) begin
                count_reg  <= '0;
                trunc_reg  <= 1'b0;
                sat_reg    <= 1'b0;
                wvalid_reg <= '0;
            end
        end
        tag1_reg.corner <= tag0.corner;
        tag1_reg.k      <= tag0.k;
        tag1_reg.j      <= tag0.j;
        tag1_reg.n      <= tag0.n;
    end

    // request capture and stage 1 address
    always_ff @(posedge aclk) begin
        if (accept) begin
            row_reg[0] <= s_row_elem_0;
            row_reg[1] <= s_row_elem_1;
            row_reg[2] <= s_row_elem_2;
            row_reg[3] <= s_row_elem_3;
            r_reg      <= s_row_index;
            end_reg    <= end_in;
        end
        waddr1_reg <= w_raddr;
    end

    // world memory, entries not yet written read as identity
    tbb_ram #(.WIDTH(DW), .DEPTH(tbb_pkg::MAT_DEPTH)) u_world_ram (
        .aclk  (aclk),
        .we    (copy1_reg),
        .waddr (waddr1_reg),
        .wdata (p_rdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    assign world_eff = wvalid_reg[waddr1_reg] ? $signed(w_rdata)
                                              : tbb_pkg::identity_elem(waddr1_reg);

    // operand select: corner vector component is +1 or -1, w is +1
    always_comb begin
        case (tag1_reg.k)
            2'd0:    v_bit = tag1_reg.n[0];
            2'd1:    v_bit = tag1_reg.n[1];
            2'd2:    v_bit = tag1_reg.n[2];
            default: v_bit = 1'b1;
        endcase
        if (tag1_reg.corner) begin
            op_a = world_eff;
            op_b = v_bit ? tbb_pkg::ONE_FX : tbb_pkg::NEG_ONE_FX;
        end else begin
            op_a = row_reg[tag1_reg.k];
            op_b = world_eff;
        end
    end

    tbb_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_tag  (tag1_reg),
        .in_a    (op_a),
        .in_b    (op_b),
        .out_tag (mac_tag),
        .out_res (mac_res),
        .out_sat (mac_sat)
    );

    // product memory, written with each finished row dot product
    assign p_we = mac_tag.valid && !mac_tag.corner && (mac_tag.k == 2'd3);

    tbb_ram #(.WIDTH(DW), .DEPTH(tbb_pkg::MAT_DEPTH)) u_product_ram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr ({r_reg, mac_tag.j}),
        .wdata (mac_res),
        .raddr (cnt_reg),
        .rdata (p_rdata)
    );

    // running bounds over corners
    always_ff @(posedge aclk) begin
        if (mac_tag.valid && mac_tag.corner && mac_tag.k == 2'd3) begin
            case (mac_tag.j)
                2'd0: begin
                    if (mac_tag.n == 3'd0 || mac_res < lo_reg[0]) lo_reg[0] <= mac_res;
                    if (mac_tag.n == 3'd0 || mac_res > hi_reg[0]) hi_reg[0] <= mac_res;
                end
                2'd1: begin
                    if (mac_tag.n == 3'd0 || mac_res < lo_reg[1]) lo_reg[1] <= mac_res;
                    if (mac_tag.n == 3'd0 || mac_res > hi_reg[1]) hi_reg[1] <= mac_res;
                end
                2'd2: begin
                    if (mac_tag.n == 3'd0 || mac_res < lo_reg[2]) lo_reg[2] <= mac_res;
                    if (mac_tag.n == 3'd0 || mac_res > hi_reg[2]) hi_reg[2] <= mac_res;
                end
                default: ;
            endcase
        end
    end

    assign m_min_x           = lo_reg[0];
    assign m_min_y           = lo_reg[1];
    assign m_min_z           = lo_reg[2];
    assign m_max_x           = hi_reg[0];
    assign m_max_y           = hi_reg[1];
    assign m_max_z           = hi_reg[2];
    assign m_chain_truncated = trunc_reg;
    assign m_saturated       = sat_reg;

endmodule
